/* rtl/upd_pkg.sv */
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and hex helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam logic [7:0] CAP_RESET  = 8'd65;

    // held_count codes
    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    // at most three data results plus the terminator per item
    localparam int MAX_DATA    = 3;
    localparam int MAX_RESULTS = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // all results caused by one accepted item
    typedef struct packed {
        logic [2:0]                   count;  // 1..4 results
        logic                         last;   // final result is the terminator
        logic [MAX_RESULTS-1:0][7:0]  bytes;
    } pkt_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        if (c <= 8'h39)
        begin
            t = c - 8'h30;
        end
        else if (c <= 8'h46)
        begin
            t = c - 8'h37;
        end
        else
        begin
            t = c - 8'h57;
        end
        return t[3:0];
    endfunction

endpackage

/* rtl/upd_front.sv */
// ----------------------------------------------------------------------------
// upd_front
// Accepts input bytes, tracks escape state and the output count, and builds
// a packet of results for the queue from each item that yields any results.
// ----------------------------------------------------------------------------
module upd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    data_byte,
    input  logic          end_of_string,
    input  logic          q_full,
    output logic          q_push,
    output upd_pkg::pkt_t q_pkt
);
    import upd_pkg::*;

    logic [7:0] capacity_reg;
    logic [1:0] held_count_reg, held_count_next;
    logic [7:0] held_digit_reg, held_digit_next;
    logic [7:0] written_reg,    written_next;
    logic       ended_reg,      ended_next;

    logic                     accept;
    logic [MAX_DATA-1:0][7:0] cand;
    logic [1:0]               n_cand;
    logic                     do_plain;
    logic [7:0]               limit;
    logic [7:0]               w;
    logic [1:0]               k;
    pkt_t                     pkt;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        cand            = '0;
        n_cand          = 2'd0;
        do_plain        = 1'b0;
        held_count_next = held_count_reg;
        held_digit_next = held_digit_reg;
        ended_next      = ended_reg;

        if (!ended_reg)
        begin
            unique case (held_count_reg)
                HELD_NONE:
                begin
                    do_plain = 1'b1;
                end
                HELD_PCT:
                begin
                    if (is_hex(data_byte))
                    begin
                        held_count_next = HELD_DIGIT;
                        held_digit_next = data_byte;
                    end
                    else
                    begin
                        cand[n_cand]    = CH_PERCENT;
                        n_cand          = n_cand + 2'd1;
                        held_count_next = HELD_NONE;
                        held_digit_next = CH_NUL;
                        do_plain        = 1'b1;
                    end
                end
                HELD_DIGIT:
                begin
                    if (is_hex(data_byte))
                    begin
                        cand[n_cand] = {hex_val(held_digit_reg), hex_val(data_byte)};
                        n_cand       = n_cand + 2'd1;
                    end
                    else
                    begin
                        cand[n_cand] = CH_PERCENT;
                        n_cand       = n_cand + 2'd1;
                        cand[n_cand] = held_digit_reg;
                        n_cand       = n_cand + 2'd1;
                        do_plain     = 1'b1;
                    end
                    held_count_next = HELD_NONE;
                    held_digit_next = CH_NUL;
                end
                default:
                begin
                    held_count_next = HELD_NONE;
                end
            endcase
        end

        if (do_plain)
        begin
            priority if (data_byte == CH_NUL)
            begin
                ended_next = 1'b1;
            end
            else if (data_byte == CH_PLUS)
            begin
                cand[n_cand] = CH_SPACE;
                n_cand       = n_cand + 2'd1;
            end
            else if (data_byte == CH_PERCENT)
            begin
                held_count_next = HELD_PCT;
            end
            else
            begin
                cand[n_cand] = data_byte;
                n_cand       = n_cand + 2'd1;
            end
        end

        // end of string: flush anything still held
        if (end_of_string)
        begin
            if (held_count_next != HELD_NONE)
            begin
                cand[n_cand] = CH_PERCENT;
                n_cand       = n_cand + 2'd1;
            end
            if (held_count_next == HELD_DIGIT)
            begin
                cand[n_cand] = held_digit_next;
                n_cand       = n_cand + 2'd1;
            end
            held_count_next = HELD_NONE;
            held_digit_next = CH_NUL;
            ended_next      = 1'b0;
        end
    end

    // capacity limit and packing
    always_comb
    begin
        limit     = (capacity_reg == 8'd0) ? 8'd0 : capacity_reg - 8'd1;
        w         = written_reg;
        k         = 2'd0;
        pkt       = '0;
        for (int i = 0; i < MAX_DATA; i++)
        begin
            if ((2'(i) < n_cand) && (w < limit))
            begin
                pkt.bytes[k] = cand[i];
                k            = k + 2'd1;
                w            = w + 8'd1;
            end
        end
        pkt.last  = end_of_string;
        pkt.count = {1'b0, k} + {2'b00, end_of_string};
        if (end_of_string)
        begin
            pkt.bytes[k] = CH_NUL;
        end
        written_next = end_of_string ? 8'd0 : w;
    end

    assign q_push = accept && (pkt.count != 3'd0);
    assign q_pkt  = pkt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= CAP_RESET;
            held_count_reg <= HELD_NONE;
            held_digit_reg <= CH_NUL;
            written_reg    <= 8'd0;
            ended_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (accept)
            begin
                held_count_reg <= held_count_next;
                held_digit_reg <= held_digit_next;
                written_reg    <= written_next;
                ended_reg      <= ended_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_ended_nothing_held: assert property (@(posedge clk) disable iff (!rst_n)
        ended_reg |-> (held_count_reg == HELD_NONE))
        else $error("escape still held after end of string data");
`endif

endmodule

/* rtl/upd_queue.sv */
// ----------------------------------------------------------------------------
// upd_queue
// Small packet queue between the front and the back end.
// ----------------------------------------------------------------------------
module upd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  upd_pkg::pkt_t push_pkt,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output upd_pkg::pkt_t head
);
    import upd_pkg::*;

    pkt_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_pkt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("queue count missed a push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

/* rtl/upd_back.sv */
// ----------------------------------------------------------------------------
// upd_back
// Walks the head packet one result at a time into the output register.
// ----------------------------------------------------------------------------
module upd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  upd_pkg::pkt_t q_head,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_byte,
    output logic          out_last
);
    import upd_pkg::*;

    logic [1:0] idx_reg,   idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg,  byte_next;
    logic       last_reg,  last_next;
    logic       load;
    logic       final_res;

    assign load      = !q_empty && (!valid_reg || !out_stall);
    assign final_res = (({1'b0, idx_reg} + 3'd1) == q_head.count);
    assign q_pop     = load && final_res;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && out_stall;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            byte_next  = q_head.bytes[idx_reg];
            last_next  = q_head.last && final_res;
            idx_next   = final_res ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

`ifndef SYNTHESIS
    a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && last_reg) |-> (byte_reg == CH_NUL))
        else $error("terminator result carries nonzero byte");
`endif

endmodule

/* rtl/url_percent_decoder.sv */
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming form-encoded string decoder: plus to space, percent-hex escapes.
// ----------------------------------------------------------------------------
// The block takes one input item per cycle unless the packet queue is full.
// The front end decodes each item combinationally into a packet of zero to
// four result items; a non-empty packet waits in a four-entry packet queue,
// and the back end sends one result per cycle while out_stall is low, from
// the head packet through an output register. An item yields one result for
// an ordinary byte and up to four for a broken escape at the end of a string.
// The first result of an item passes through the packet queue and the output
// register. in_stall rises only when the packet queue is full. The capacity
// register is written through cfg_we and cfg_wdata and resets to 65.
module url_percent_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_string,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);
    import upd_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_empty;
    pkt_t q_pkt;
    pkt_t q_head;

    upd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_pkt         (q_pkt)
    );

    upd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_pkt (q_pkt),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    upd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the URL percent decoder: plus to space, percent-hex escapes, broken
// escapes, zero bytes that end a string early, and the per-string capacity
// limit. Decoded characters are matched against an in-bench decoder, or
// against listed results in typed rows. The run has a short directed table,
// then random strings under several capacity settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import upd_pkg::*;

    localparam int QUIET_CYCLES = 6;
    localparam int STALL_LIMIT  = 1000;
    localparam int N_DIR        = 25;
    localparam int N_PHASE      = 8;
    localparam int PHASE_ITEMS  = 48;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } dec_char_t;

    // typed = 1: the n results are given in r, first one in the top byte
    typedef struct packed {
        logic [7:0]  d;
        logic        e;
        logic        typed;
        logic [2:0]  n;
        logic [31:0] r;
    } stim_row_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       cfg_we        = 1'b0;
    logic [7:0] cfg_wdata     = 8'd0;
    logic       in_valid      = 1'b0;
    logic [7:0] data_byte     = 8'd0;
    logic       end_of_string = 1'b0;
    logic       out_stall     = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_last;

    // decoder model state
    logic [7:0] cap_reg   = CAP_RESET;
    logic [1:0] held_cnt  = HELD_NONE;
    logic [7:0] held_chr  = 8'd0;
    logic [7:0] sent_cnt  = 8'd0;
    logic       str_done  = 1'b0;

    dec_char_t  decoded_due[$];
    dec_char_t  step_chars[$];
    dec_char_t  got_due;

    int         src_idle_pct = 0;
    int         snk_stall_pct = 0;
    int         err_cnt = 0;
    int         quiet_cycles = 0;

    stim_row_t dir_rows [N_DIR] = '{
        '{8'h61,      1'b0, 1'b1, 3'd1, 32'h6100_0000},
        '{CH_PLUS,    1'b0, 1'b1, 3'd1, {CH_SPACE, 24'h0}},
        '{CH_PERCENT, 1'b0, 1'b1, 3'd0, 32'h0},
        '{8'h34,      1'b0, 1'b1, 3'd0, 32'h0},
        '{8'h31,      1'b0, 1'b1, 3'd1, 32'h4100_0000},
        '{CH_PERCENT, 1'b0, 1'b1, 3'd0, 32'h0},
        '{8'h66,      1'b0, 1'b1, 3'd0, 32'h0},
        '{8'h46,      1'b0, 1'b1, 3'd1, 32'hFF00_0000},
        '{CH_PERCENT, 1'b0, 1'b1, 3'd0, 32'h0},
        '{8'h47,      1'b0, 1'b1, 3'd2, {CH_PERCENT, 8'h47, 16'h0}},
        '{CH_PERCENT, 1'b0, 1'b1, 3'd0, 32'h0},
        '{8'h64,      1'b0, 1'b1, 3'd0, 32'h0},
        '{8'h78,      1'b1, 1'b1, 3'd4, {CH_PERCENT, 8'h64, 8'h78, CH_NUL}},
        '{8'hFF,      1'b0, 1'b1, 3'd1, 32'hFF00_0000},
        '{8'h80,      1'b0, 1'b0, 3'd0, 32'h0},
        '{CH_PERCENT, 1'b0, 1'b1, 3'd0, 32'h0},
        '{8'h35,      1'b0, 1'b1, 3'd0, 32'h0},
        '{CH_NUL,     1'b0, 1'b1, 3'd2, {CH_PERCENT, 8'h35, 16'h0}},
        '{8'h71,      1'b0, 1'b1, 3'd0, 32'h0},
        '{8'h72,      1'b1, 1'b1, 3'd1, 32'h0},
        '{CH_NUL,     1'b1, 1'b1, 3'd1, 32'h0},
        '{CH_PERCENT, 1'b1, 1'b1, 3'd2, {CH_PERCENT, 24'h0}},
        '{CH_PERCENT, 1'b0, 1'b0, 3'd0, 32'h0},
        '{8'h30,      1'b0, 1'b0, 3'd0, 32'h0},
        '{8'h30,      1'b1, 1'b0, 3'd0, 32'h0}
    };

    url_percent_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .out_last      (out_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------
    // {valid, value}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return {1'b1, c[3:0]};
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    function automatic void put_data(input logic [7:0] b);
        logic [7:0] lim;
        lim = (cap_reg == 8'd0) ? 8'd0 : cap_reg - 8'd1;
        if (sent_cnt < lim)
        begin
            step_chars.push_back(dec_char_t'{b, 1'b0});
            sent_cnt = sent_cnt + 8'd1;
        end
    endfunction

    function automatic void flush_held();
        if (held_cnt != HELD_NONE)
        begin
            put_data(CH_PERCENT);
        end
        if (held_cnt == HELD_DIGIT)
        begin
            put_data(held_chr);
        end
        held_cnt = HELD_NONE;
        held_chr = 8'd0;
    endfunction

    function automatic void take_plain(input logic [7:0] b);
        if (b == CH_NUL)
        begin
            str_done = 1'b1;
        end
        else if (b == CH_PLUS)
        begin
            put_data(CH_SPACE);
        end
        else if (b == CH_PERCENT)
        begin
            held_cnt = HELD_PCT;
        end
        else
        begin
            put_data(b);
        end
    endfunction

    function automatic void decode_item(input logic [7:0] b, input logic e);
        logic [4:0] nib_new;
        logic [4:0] nib_old;
        step_chars.delete();
        nib_new = hex_nibble(b);
        nib_old = hex_nibble(held_chr);
        if (!str_done)
        begin
            if (held_cnt == HELD_NONE)
            begin
                take_plain(b);
            end
            else if (held_cnt == HELD_PCT && nib_new[4])
            begin
                held_chr = b;
                held_cnt = HELD_DIGIT;
            end
            else if (held_cnt == HELD_DIGIT && nib_new[4])
            begin
                held_cnt = HELD_NONE;
                held_chr = 8'd0;
                put_data({nib_old[3:0], nib_new[3:0]});
            end
            else
            begin
                flush_held();
                take_plain(b);
            end
        end
        if (e)
        begin
            flush_held();
            step_chars.push_back(dec_char_t'{CH_NUL, 1'b1});
            held_cnt = HELD_NONE;
            held_chr = 8'd0;
            sent_cnt = 8'd0;
            str_done = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10)
        begin
            return 8'(8'h30 + v);
        end
        return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + v - 10);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] b;
        logic [4:0] nib;
        do
        begin
            b = 8'($urandom_range(255));
            nib = hex_nibble(b);
        end
        while (nib[4]);
        return b;
    endfunction

    // called right after the clock rises; returns once the item has been taken
    task automatic present_item(input logic [7:0] d, input logic e);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= d;
        end_of_string <= e;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    task automatic send_and_decode(input logic [7:0] d, input logic e);
        decode_item(d, e);
        foreach (step_chars[i])
        begin
            decoded_due.push_back(step_chars[i]);
        end
        present_item(d, e);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (decoded_due.size() != 0);
        // zero-result items may still be in flight
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [7:0] v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cap_reg = v;
    endtask

    // random strings built from tokens; a phase may stop mid-string
    task automatic random_phase(input int n_items, input int pause_at);
        int         done_cnt;
        int         ntok;
        int         r;
        logic       is_end;
        logic [7:0] str_q[$];
        done_cnt = 0;
        while (done_cnt < n_items)
        begin
            str_q.delete();
            ntok = $urandom_range(1, 10);
            for (int t = 0; t < ntok; t++)
            begin
                r = $urandom_range(99);
                if (r < 30)
                begin
                    str_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
                end
                else if (r < 40)
                begin
                    str_q.push_back(CH_PLUS);
                end
                else if (r < 70)
                begin
                    str_q.push_back(CH_PERCENT);
                    str_q.push_back(hex_char());
                    str_q.push_back(hex_char());
                end
                else if (r < 78)
                begin
                    str_q.push_back(CH_PERCENT);
                    str_q.push_back(non_hex_char());
                end
                else if (r < 84)
                begin
                    str_q.push_back(CH_PERCENT);
                    str_q.push_back(hex_char());
                    str_q.push_back(non_hex_char());
                end
                else if (r < 88)
                begin
                    str_q.push_back(CH_NUL);
                end
                else if (r < 95)
                begin
                    str_q.push_back(8'($urandom_range(255)));
                end
                else
                begin
                    str_q.push_back(CH_PERCENT);
                end
            end
            foreach (str_q[i])
            begin
                is_end = (i == str_q.size() - 1);
                send_and_decode(str_q[i], is_end);
                done_cnt++;
                if (done_cnt == pause_at)
                begin
                    drain_results();
                end
                if (done_cnt >= n_items)
                begin
                    break;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // result check and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_due.size() == 0)
            begin
                $display("%0t ns: unexpected item, out_byte %02h out_last %0b",
                         $time, out_byte, out_last);
                err_cnt++;
            end
            else
            begin
                got_due = decoded_due.pop_front();
                if (out_byte !== got_due.ch)
                begin
                    $display("%0t ns: out_byte expected %02h, got %02h",
                             $time, got_due.ch, out_byte);
                    err_cnt++;
                end
                if (out_last !== got_due.last)
                begin
                    $display("%0t ns: out_last expected %0b, got %0b",
                             $time, got_due.last, out_last);
                    err_cnt++;
                end
            end
        end
        out_stall <= (snk_stall_pct != 0) && ($urandom_range(99) < snk_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("[url_percent_decoder] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        stim_row_t  row;
        logic [7:0] phase_cap [N_PHASE];
        int         phase_src [N_PHASE];
        int         phase_snk [N_PHASE];
        int         phase_pause [N_PHASE];

        phase_cap   = '{8'd255, 8'd1, 8'd0, 8'd3, 8'd8,
                        8'($urandom_range(2, 40)), CAP_RESET, 8'd20};
        phase_src   = '{0, 46, 0, 33, 0, 46, 0, 33};
        phase_snk   = '{0, 0, 46, 33, 0, 0, 46, 33};
        phase_pause = '{0, 0, 0, 0, 20, 0, 0, 0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, capacity at its reset value
        for (int k = 0; k < N_DIR; k++)
        begin
            row = dir_rows[k];
            if (row.typed)
            begin
                decode_item(row.d, row.e);
                for (int i = 0; i < row.n; i++)
                begin
                    decoded_due.push_back(dec_char_t'{row.r[31 - 8*i -: 8],
                                                      row.e && (i == row.n - 1)});
                end
                present_item(row.d, row.e);
            end
            else
            begin
                send_and_decode(row.d, row.e);
            end
        end

        for (int p = 0; p < N_PHASE; p++)
        begin
            set_capacity(phase_cap[p]);
            src_idle_pct  = phase_src[p];
            snk_stall_pct = phase_snk[p];
            random_phase(PHASE_ITEMS, phase_pause[p]);
        end

        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (decoded_due.size() != 0);
        repeat (2 * QUIET_CYCLES) @(posedge clk);

        if (err_cnt == 0)
        begin
            $display("[url_percent_decoder] OK");
        end
        else
        begin
            $display("[url_percent_decoder] ERROR");
        end
        $finish;
    end

endmodule
